// File: hdl/i2cbs_pkg.sv
// ----------------------------------------------------------------------------
// i2cbs_pkg
// shared types and constants of the i2c master bit sequencer
// ----------------------------------------------------------------------------
package i2cbs_pkg;

	// command codes carried in the mode field
	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_SEND  = 3'd3;
	localparam logic [2:0] CMD_WAIT  = 3'd4;
	localparam logic [2:0] CMD_READ  = 3'd5;

	// register map, word index
	localparam logic REG_ACK_TIMEOUT = 1'b0;

	localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;
	localparam logic [7:0] RX_MSB          = 8'h80;
	localparam logic [3:0] BITS_PER_BYTE   = 4'd8;

	// sequence phase
	typedef enum logic [3:0] {
		PH_IDLE  = 4'd0,
		PH_S0    = 4'd1,
		PH_S1    = 4'd2,
		PH_S2    = 4'd3,
		PH_P0    = 4'd4,
		PH_P1    = 4'd5,
		PH_BITL  = 4'd6,
		PH_BITH  = 4'd7,
		PH_WA0   = 4'd8,
		PH_WAH   = 4'd9,
		PH_WAEND = 4'd10,
		PH_AKD   = 4'd11,
		PH_AKH   = 4'd12,
		PH_AKL   = 4'd13,
		PH_AKR   = 4'd14
	} phase_t;

endpackage

// File: hdl/i2cbs_if.sv
// ----------------------------------------------------------------------------
// i2cbs channel interfaces
// tick input channel and per-tick result channel, valid/ready handshake
// ----------------------------------------------------------------------------

// one bit-delay tick: sampled sda and optional command
interface i2cbs_tick_if;
	logic       valid;
	logic       ready;
	logic [2:0] mode;
	logic [7:0] tx_byte;
	logic       ack_to_send;
	logic       sda_in;

	modport source (output valid, mode, tx_byte, ack_to_send, sda_in, input ready);
	modport sink   (input valid, mode, tx_byte, ack_to_send, sda_in, output ready);
endinterface

// pin levels and status for one tick
interface i2cbs_result_if;
	logic       valid;
	logic       ready;
	logic       scl_out;
	logic       sda_out;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       nack;

	modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte, nack,
		input ready);
	modport sink   (input valid, scl_out, sda_out, busy_res, done_res, rx_byte, nack,
		output ready);
endinterface

// File: hdl/i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// pin-level i2c master stepping start, stop, send, wait-ack and read sequences
// ----------------------------------------------------------------------------
// Each beat on the tick channel is one bit delay of the bus and yields exactly
// one beat on the result channel with the SCL/SDA drive levels for that delay.
// The block takes one tick per clock cycle unless result.ready holds it off;
// a tick is captured in an input register and its result is then registered
// in the output register. The sequencer state updates in one combinational
// pass per tick, which is what lets ticks follow back to back. A command
// presented while busy is ignored. ack_timeout is at word 0 of the APB port.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration port
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	// channels
	i2cbs_tick_if.sink             tick,
	i2cbs_result_if.source         result
);

	// configuration
	logic [7:0] ack_timeout_q;

	// input stage
	logic       valid_s1;
	logic [2:0] mode_s1;
	logic [7:0] tx_byte_s1;
	logic       ack_to_send_s1;
	logic       sda_in_s1;

	// sequencer state
	i2cbs_pkg::phase_t phase_q;
	logic [2:0] cmd_q;
	logic [3:0] bit_idx_q;
	logic [7:0] tx_shift_q;
	logic [7:0] rx_shift_q;
	logic [7:0] poll_cnt_q;
	logic       scl_q;
	logic       sda_q;
	logic       ack_lat_q;
	logic       nack_q;

	// result stage
	logic       valid_s2;
	logic       scl_s2;
	logic       sda_s2;
	logic       busy_s2;
	logic       done_s2;
	logic [7:0] rx_byte_s2;
	logic       nack_s2;

	// next state
	i2cbs_pkg::phase_t phase_n;
	logic [2:0] cmd_n;
	logic [3:0] bit_idx_n;
	logic [7:0] tx_shift_n;
	logic [7:0] rx_shift_n;
	logic [7:0] poll_cnt_n;
	logic       scl_n;
	logic       sda_n;
	logic       ack_lat_n;
	logic       nack_n;
	logic       out_scl;
	logic       out_sda;
	logic       out_busy;
	logic       out_done;

	logic advance;
	logic tick_acc;
	logic cfg_wr;

	// apb register access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == i2cbs_pkg::REG_ACK_TIMEOUT);
	assign prdata = (paddr[2] == i2cbs_pkg::REG_ACK_TIMEOUT) ? {24'd0, ack_timeout_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_timeout_q <= i2cbs_pkg::ACK_TIMEOUT_RST;
		end else if (cfg_wr) begin
			ack_timeout_q <= pwdata[7:0];
		end
	end

	// handshake: stage 1 moves on when the result register is free or drained
	assign advance  = valid_s1 && (!valid_s2 || result.ready);
	assign tick.ready = !valid_s1 || advance;
	assign tick_acc = tick.valid && tick.ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			mode_s1        <= tick.mode;
			tx_byte_s1     <= tick.tx_byte;
			ack_to_send_s1 <= tick.ack_to_send;
			sda_in_s1      <= tick.sda_in;
		end
	end

	// one tick of the sequencer
	always_comb begin
		phase_n    = phase_q;
		cmd_n      = cmd_q;
		bit_idx_n  = bit_idx_q;
		tx_shift_n = tx_shift_q;
		rx_shift_n = rx_shift_q;
		poll_cnt_n = poll_cnt_q;
		scl_n      = scl_q;
		sda_n      = sda_q;
		ack_lat_n  = ack_lat_q;
		nack_n     = nack_q;
		out_done   = 1'b0;

		// command launch when idle
		if (phase_q == i2cbs_pkg::PH_IDLE &&
				mode_s1 inside {[i2cbs_pkg::CMD_START:i2cbs_pkg::CMD_READ]}) begin
			cmd_n      = mode_s1;
			bit_idx_n  = 4'd0;
			poll_cnt_n = 8'd0;
			case (mode_s1)
				i2cbs_pkg::CMD_START: begin
					phase_n = i2cbs_pkg::PH_S0;
				end
				i2cbs_pkg::CMD_STOP: begin
					phase_n = i2cbs_pkg::PH_P0;
				end
				i2cbs_pkg::CMD_SEND: begin
					tx_shift_n = tx_byte_s1;
					phase_n    = i2cbs_pkg::PH_BITL;
				end
				i2cbs_pkg::CMD_WAIT: begin
					phase_n = i2cbs_pkg::PH_WA0;
				end
				default: begin
					ack_lat_n  = ack_to_send_s1;
					rx_shift_n = 8'd0;
					sda_n      = 1'b1;
					phase_n    = i2cbs_pkg::PH_BITH;
				end
			endcase
		end

		out_busy = (phase_n != i2cbs_pkg::PH_IDLE);

		// phase step
		case (phase_n)
			i2cbs_pkg::PH_IDLE: begin
			end
			i2cbs_pkg::PH_S0: begin
				scl_n   = 1'b1;
				sda_n   = 1'b1;
				phase_n = i2cbs_pkg::PH_S1;
			end
			i2cbs_pkg::PH_S1: begin
				sda_n   = 1'b0;
				phase_n = i2cbs_pkg::PH_S2;
			end
			i2cbs_pkg::PH_S2: begin
				scl_n    = 1'b0;
				out_done = 1'b1;
				phase_n  = i2cbs_pkg::PH_IDLE;
			end
			i2cbs_pkg::PH_P0: begin
				sda_n   = 1'b0;
				scl_n   = 1'b1;
				phase_n = i2cbs_pkg::PH_P1;
			end
			i2cbs_pkg::PH_P1: begin
				sda_n = 1'b1;
				if (cmd_n == i2cbs_pkg::CMD_WAIT) begin
					phase_n = i2cbs_pkg::PH_WAEND;
				end else begin
					out_done = 1'b1;
					phase_n  = i2cbs_pkg::PH_IDLE;
				end
			end
			i2cbs_pkg::PH_BITL: begin
				if (cmd_n == i2cbs_pkg::CMD_SEND) begin
					sda_n   = tx_shift_n[7];
					phase_n = i2cbs_pkg::PH_BITH;
				end else begin
					scl_n     = 1'b0;
					bit_idx_n = bit_idx_n + 4'd1;
					phase_n   = (bit_idx_n >= i2cbs_pkg::BITS_PER_BYTE) ?
						i2cbs_pkg::PH_AKD : i2cbs_pkg::PH_BITH;
				end
			end
			i2cbs_pkg::PH_BITH: begin
				scl_n = 1'b1;
				if (cmd_n == i2cbs_pkg::CMD_SEND) begin
					tx_shift_n = {tx_shift_n[6:0], 1'b0};
					bit_idx_n  = bit_idx_n + 4'd1;
					if (bit_idx_n >= i2cbs_pkg::BITS_PER_BYTE) begin
						out_done = 1'b1;
						phase_n  = i2cbs_pkg::PH_IDLE;
					end else begin
						phase_n = i2cbs_pkg::PH_BITL;
					end
				end else begin
					if (sda_in_s1) begin
						rx_shift_n = rx_shift_n | (i2cbs_pkg::RX_MSB >> bit_idx_n[2:0]);
					end
					phase_n = i2cbs_pkg::PH_BITL;
				end
			end
			i2cbs_pkg::PH_WA0: begin
				sda_n   = 1'b1;
				phase_n = i2cbs_pkg::PH_WAH;
			end
			i2cbs_pkg::PH_WAH: begin
				scl_n = 1'b1;
				if (!sda_in_s1) begin
					ack_lat_n = 1'b0;
					phase_n   = i2cbs_pkg::PH_WAEND;
				end else if (poll_cnt_n >= ack_timeout_q) begin
					ack_lat_n = 1'b1;
					phase_n   = i2cbs_pkg::PH_P0;
				end else begin
					poll_cnt_n = poll_cnt_n + 8'd1;
				end
			end
			i2cbs_pkg::PH_WAEND: begin
				scl_n    = 1'b0;
				nack_n   = ack_lat_n;
				out_done = 1'b1;
				phase_n  = i2cbs_pkg::PH_IDLE;
			end
			i2cbs_pkg::PH_AKD: begin
				sda_n   = ack_lat_n;
				phase_n = i2cbs_pkg::PH_AKH;
			end
			i2cbs_pkg::PH_AKH: begin
				scl_n   = 1'b1;
				phase_n = i2cbs_pkg::PH_AKL;
			end
			i2cbs_pkg::PH_AKL: begin
				scl_n   = 1'b0;
				phase_n = i2cbs_pkg::PH_AKR;
			end
			i2cbs_pkg::PH_AKR: begin
				sda_n    = 1'b1;
				out_done = 1'b1;
				phase_n  = i2cbs_pkg::PH_IDLE;
			end
			default: begin
				phase_n = i2cbs_pkg::PH_IDLE;
			end
		endcase

		// levels shown this tick, then the end-of-bit release after a send
		out_scl = scl_n;
		out_sda = sda_n;
		if (phase_q != i2cbs_pkg::PH_IDLE && phase_q == i2cbs_pkg::PH_BITH &&
				cmd_q == i2cbs_pkg::CMD_SEND) begin
			scl_n = 1'b0;
			if (out_done) begin
				sda_n = 1'b1;
			end
		end
	end

	// sequencer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= i2cbs_pkg::PH_IDLE;
			cmd_q      <= i2cbs_pkg::CMD_NONE;
			bit_idx_q  <= 4'd0;
			tx_shift_q <= 8'd0;
			rx_shift_q <= 8'd0;
			poll_cnt_q <= 8'd0;
			scl_q      <= 1'b1;
			sda_q      <= 1'b1;
			ack_lat_q  <= 1'b0;
			nack_q     <= 1'b0;
		end else if (advance) begin
			phase_q    <= phase_n;
			cmd_q      <= cmd_n;
			bit_idx_q  <= bit_idx_n;
			tx_shift_q <= tx_shift_n;
			rx_shift_q <= rx_shift_n;
			poll_cnt_q <= poll_cnt_n;
			scl_q      <= scl_n;
			sda_q      <= sda_n;
			ack_lat_q  <= ack_lat_n;
			nack_q     <= nack_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			scl_s2     <= out_scl;
			sda_s2     <= out_sda;
			busy_s2    <= out_busy;
			done_s2    <= out_done;
			rx_byte_s2 <= rx_shift_n;
			nack_s2    <= nack_n;
		end
	end

	assign result.valid    = valid_s2;
	assign result.scl_out  = scl_s2;
	assign result.sda_out  = sda_s2;
	assign result.busy_res = busy_s2;
	assign result.done_res = done_s2;
	assign result.rx_byte  = rx_byte_s2;
	assign result.nack     = nack_s2;

	// checks

	// a done beat always belongs to a command
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && out_done) |-> out_busy)
		else $error("done without busy");

	// a finished command leaves the sequencer idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && out_done) |=> (phase_q == i2cbs_pkg::PH_IDLE))
		else $error("sequencer not idle after done");

	// a held tick is never overwritten
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |-> !tick.ready)
		else $error("input stage overwritten");

	// nack only moves on the done beat of a command
	a_nack_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !out_done) |=> $stable(nack_q))
		else $error("nack changed outside done");

endmodule
